>>> src/command_admission_window_gate_top_assert.svh
// Assertion macros shared by the command admission window gate RTL.
// Included by the modules that check their own sequencing; needs nothing else.
`ifndef COMMAND_ADMISSION_WINDOW_GATE_TOP_ASSERT_SVH
`define COMMAND_ADMISSION_WINDOW_GATE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAWG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CAWG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/cawg_pkg.sv
// Shared types and constants for the command admission window gate.
// Used by cawg_rem, cawg_ctrl and the top level; depends on nothing.
package cawg_pkg;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 80;
	localparam int CMD_W       = 3;

	// command codes
	typedef enum logic [2:0] {
		CMD_NOOP      = 3'd0,
		CMD_RESET     = 3'd1,
		CMD_ADVANCE   = 3'd2,
		CMD_TOGGLE    = 3'd3,
		CMD_HOUSEKEEP = 3'd4
	} cmd_t;

	// gate profiles
	localparam logic [1:0] PROF_OPEN     = 2'd0;
	localparam logic [1:0] PROF_PERIODIC = 2'd1;
	localparam logic [1:0] PROF_PROB     = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_POLICY_PROFILE = 3'd0;
	localparam logic [2:0] REG_STAGGERED      = 3'd1;
	localparam logic [2:0] REG_PERIOD_SEC     = 3'd2;
	localparam logic [2:0] REG_PHASE_SEC      = 3'd3;
	localparam logic [2:0] REG_OPEN_LEN_SEC   = 3'd4;
	localparam logic [2:0] REG_SEED_BASE      = 3'd5;
	localparam logic [2:0] REG_INTERVAL_A     = 3'd6;
	localparam logic [2:0] REG_INTERVAL_B     = 3'd7;

	localparam logic [31:0] LCG_MUL        = 32'd1103515245;
	localparam logic [31:0] LCG_ADD        = 32'd12345;
	localparam logic [31:0] SEED_XOR       = 32'h5A5A5A5A;
	localparam logic [31:0] SEED_DEFAULT   = 32'h4D4F4445;
	localparam logic [31:0] CYCLE_SEC      = 32'd40;
	localparam logic [31:0] FIRST_OPEN_SEC = 32'd20;
	localparam logic [6:0]  W1_PCT         = 7'd10;
	localparam logic [6:0]  W2_PCT         = 7'd90;
	localparam logic [31:0] DRAW_MOD       = 32'd100;

	localparam logic [31:0] PERIOD_RESET   = 32'd16;
	localparam logic [31:0] OPEN_LEN_RESET = 32'd6;
	localparam logic [31:0] SEED_RESET     = 32'd1297040453;
	localparam logic [63:0] INTERVAL_RESET = 64'h0000_0001_0000_0000;

	// remainder unit pass lengths
	localparam logic [5:0] DIV_FULL = 6'd32;
	localparam logic [5:0] DIV_HALF = 6'd16;

	typedef struct packed {
		logic [1:0]  profile;
		logic        staggered;
		logic [31:0] period;
		logic [31:0] phase;
		logic [31:0] open_len;
		logic [31:0] seed_base;
		logic [31:0] ia_lo;
		logic [31:0] ia_hi;
		logic [31:0] ib_lo;
		logic [31:0] ib_hi;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
		logic [5:0]  iters;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic        accepted;
		logic [7:0]  cmd_count;
		logic [7:0]  err_count;
		logic [1:0]  active_mode;
		logic        policy_enabled;
		logic [15:0] mode_change_count;
		logic [31:0] age_sec;
		logic [6:0]  draw_value;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ELAPSED,
		ST_PER_START,
		ST_PER_WAIT,
		ST_PROB_START,
		ST_PROB_WAIT,
		ST_DRAW_WAIT,
		ST_APPLY,
		ST_DONE
	} state_t;

endpackage

>>> src/cawg_rem.sv
// Shared restoring remainder unit, one quotient bit per cycle.
// Depends on cawg_pkg (request and response structs) and the assertion header.
`include "command_admission_window_gate_top_assert.svh"

module cawg_rem (
	input  logic                clk,
	input  logic                arst_n,
	input  cawg_pkg::div_req_t  req,
	output cawg_pkg::div_rsp_t  rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        fits;

	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= fits ? diff[31:0] : trial[31:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

	`CAWG_ASSERT_NOW(a_rem_below_divisor, clk, arst_n, done_q, rem_q < dvs_q,
		"remainder not below divisor")
	`CAWG_ASSERT_NOW(a_no_restart_busy, clk, arst_n, req.start, !busy_q,
		"remainder unit started while busy")
	`CAWG_ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q,
		"remainder done held for more than one cycle")

endmodule

>>> src/cawg_ctrl.sv
// Command sequencer, gate evaluation and window state for the admission gate.
// Depends on cawg_pkg; drives the shared cawg_rem unit through a request struct.
`include "command_admission_window_gate_top_assert.svh"

module cawg_ctrl #(
	parameter int COUNT_WIDTH  = 8,
	parameter int CHANGE_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2:0]          cmd,
	input  logic [31:0]         now_sec,
	input  cawg_pkg::cfg_t      cfg,
	output cawg_pkg::div_req_t  div_req,
	input  cawg_pkg::div_rsp_t  div_rsp,
	output logic                m_tvalid,
	input  logic                m_tready,
	output cawg_pkg::res_t      res
);

	cawg_pkg::state_t state_q, state_d;

	// window and counter state
	logic [31:0]             epoch_q;
	logic                    epoch_valid_q;
	logic [31:0]             seed_q;
	logic [COUNT_WIDTH-1:0]  acc_cnt_q;
	logic [COUNT_WIDTH-1:0]  err_cnt_q;
	logic [1:0]              mode_q;
	logic                    flag_q;
	logic [CHANGE_WIDTH-1:0] chg_cnt_q;
	logic                    out_valid_q;

	// per-item working registers
	logic [2:0]              cmd_q;
	logic [31:0]             now_q;
	logic [31:0]             elapsed_q;
	logic [6:0]              draw_q;
	logic [6:0]              pct_q;
	logic                    hits_q;
	logic                    gate_q;
	logic                    acc_q;
	cawg_pkg::res_t          res_q;

	logic        out_free;
	logic        is_gated;
	logic        need_wreset;
	logic [31:0] seed_pick;
	logic [31:0] seed_mix;
	logic [31:0] seed_init;
	logic [31:0] per_x;
	logic        ia_hit;
	logic        ib_hit;
	logic        w1;
	logic        w2;
	logic [6:0]  pct_d;

	assign out_free = !out_valid_q || m_tready;
	assign is_gated = (cmd_q == cawg_pkg::CMD_ADVANCE) || (cmd_q == cawg_pkg::CMD_TOGGLE);

	assign seed_pick = (cfg.seed_base == '0) ? cawg_pkg::SEED_DEFAULT : cfg.seed_base;
	assign seed_mix  = seed_pick ^ cawg_pkg::SEED_XOR;
	assign seed_init = (seed_mix == '0) ? cawg_pkg::SEED_DEFAULT : seed_mix;

	assign need_wreset = ((cfg.profile == cawg_pkg::PROF_PERIODIC) && !epoch_valid_q) ||
		((cfg.profile == cawg_pkg::PROF_PROB) && (!epoch_valid_q || seed_q == '0));

	assign per_x  = elapsed_q + cfg.period - cfg.phase;
	assign ia_hit = (elapsed_q >= cfg.ia_lo) && (elapsed_q <= cfg.ia_hi);
	assign ib_hit = (elapsed_q >= cfg.ib_lo) && (elapsed_q <= cfg.ib_hi);

	assign w1    = div_rsp.rem < cawg_pkg::FIRST_OPEN_SEC;
	assign w2    = cfg.staggered ? !w1 : w1;
	assign pct_d = (w1 ? cawg_pkg::W1_PCT : 7'd0) + (w2 ? cawg_pkg::W2_PCT : 7'd0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cawg_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = cawg_pkg::ST_DECODE;
			end
			cawg_pkg::ST_DECODE: begin
				if (!is_gated) begin
					state_d = cawg_pkg::ST_DONE;
				end else if (cfg.profile == cawg_pkg::PROF_PERIODIC ||
						cfg.profile == cawg_pkg::PROF_PROB) begin
					state_d = cawg_pkg::ST_ELAPSED;
				end else begin
					state_d = cawg_pkg::ST_APPLY;
				end
			end
			cawg_pkg::ST_ELAPSED: begin
				state_d = (cfg.profile == cawg_pkg::PROF_PERIODIC) ?
					cawg_pkg::ST_PER_START : cawg_pkg::ST_PROB_START;
			end
			cawg_pkg::ST_PER_START: begin
				state_d = (cfg.period == '0) ? cawg_pkg::ST_APPLY : cawg_pkg::ST_PER_WAIT;
			end
			cawg_pkg::ST_PER_WAIT: begin
				if (div_rsp.done) state_d = cawg_pkg::ST_APPLY;
			end
			cawg_pkg::ST_PROB_START: begin
				state_d = cawg_pkg::ST_PROB_WAIT;
			end
			cawg_pkg::ST_PROB_WAIT: begin
				if (div_rsp.done) state_d = cawg_pkg::ST_DRAW_WAIT;
			end
			cawg_pkg::ST_DRAW_WAIT: begin
				if (div_rsp.done) state_d = cawg_pkg::ST_APPLY;
			end
			cawg_pkg::ST_APPLY: begin
				state_d = cawg_pkg::ST_DONE;
			end
			cawg_pkg::ST_DONE: begin
				if (out_free) state_d = cawg_pkg::ST_IDLE;
			end
			default: begin
				state_d = cawg_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		div_req.iters    = '0;
		case (state_q)
			cawg_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			cawg_pkg::ST_PER_START: begin
				div_req.start    = (cfg.period != '0);
				div_req.dividend = per_x;
				div_req.divisor  = cfg.period;
				div_req.iters    = cawg_pkg::DIV_FULL;
			end
			cawg_pkg::ST_PROB_START: begin
				div_req.start    = 1'b1;
				div_req.dividend = elapsed_q;
				div_req.divisor  = cawg_pkg::CYCLE_SEC;
				div_req.iters    = cawg_pkg::DIV_FULL;
			end
			cawg_pkg::ST_PROB_WAIT: begin
				// draw takes the upper half of the seed, left-aligned for a short pass
				div_req.start    = div_rsp.done;
				div_req.dividend = {seed_q[31:16], 16'h0000};
				div_req.divisor  = cawg_pkg::DRAW_MOD;
				div_req.iters    = cawg_pkg::DIV_HALF;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= cawg_pkg::ST_IDLE;
			epoch_q       <= '0;
			epoch_valid_q <= 1'b0;
			seed_q        <= '0;
			acc_cnt_q     <= '0;
			err_cnt_q     <= '0;
			mode_q        <= '0;
			flag_q        <= 1'b1;
			chg_cnt_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				cawg_pkg::ST_DECODE: begin
					case (cmd_q)
						cawg_pkg::CMD_NOOP: begin
							acc_cnt_q <= acc_cnt_q + 1'b1;
						end
						cawg_pkg::CMD_RESET: begin
							epoch_q       <= now_q;
							epoch_valid_q <= 1'b1;
							seed_q        <= seed_init;
							acc_cnt_q     <= '0;
							err_cnt_q     <= '0;
							mode_q        <= '0;
							flag_q        <= 1'b1;
							chg_cnt_q     <= '0;
						end
						cawg_pkg::CMD_ADVANCE, cawg_pkg::CMD_TOGGLE: begin
							if (need_wreset) begin
								epoch_q       <= now_q;
								epoch_valid_q <= 1'b1;
								seed_q        <= seed_init;
							end
						end
						default: begin
							mode_q <= mode_q;
						end
					endcase
				end
				cawg_pkg::ST_PROB_START: begin
					seed_q <= seed_q * cawg_pkg::LCG_MUL + cawg_pkg::LCG_ADD;
				end
				cawg_pkg::ST_APPLY: begin
					if (gate_q) begin
						acc_cnt_q <= acc_cnt_q + 1'b1;
						chg_cnt_q <= chg_cnt_q + 1'b1;
						if (cmd_q == cawg_pkg::CMD_ADVANCE) begin
							case (mode_q)
								2'd0:    mode_q <= 2'd1;
								2'd1:    mode_q <= 2'd2;
								2'd3:    mode_q <= 2'd1;
								default: mode_q <= 2'd0;
							endcase
						end else begin
							flag_q <= !flag_q;
						end
					end else begin
						err_cnt_q <= err_cnt_q + 1'b1;
					end
				end
				default: begin
					epoch_q <= epoch_q;
				end
			endcase
			if (state_q == cawg_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cawg_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd_q <= cmd;
					now_q <= now_sec;
				end
			end
			cawg_pkg::ST_DECODE: begin
				elapsed_q <= '0;
				draw_q    <= '0;
				gate_q    <= 1'b1;
				acc_q     <= cmd_q inside {cawg_pkg::CMD_NOOP, cawg_pkg::CMD_RESET,
					cawg_pkg::CMD_HOUSEKEEP};
			end
			cawg_pkg::ST_ELAPSED: begin
				elapsed_q <= now_q - epoch_q;
			end
			cawg_pkg::ST_PER_START: begin
				hits_q <= ia_hit || ib_hit;
				gate_q <= ia_hit || ib_hit;
			end
			cawg_pkg::ST_PER_WAIT: begin
				if (div_rsp.done) gate_q <= (div_rsp.rem < cfg.open_len) || hits_q;
			end
			cawg_pkg::ST_PROB_WAIT: begin
				if (div_rsp.done) pct_q <= pct_d;
			end
			cawg_pkg::ST_DRAW_WAIT: begin
				if (div_rsp.done) begin
					draw_q <= div_rsp.rem[6:0];
					gate_q <= div_rsp.rem < {25'd0, pct_q};
				end
			end
			cawg_pkg::ST_APPLY: begin
				acc_q <= gate_q;
			end
			cawg_pkg::ST_DONE: begin
				if (out_free) begin
					res_q.accepted          <= acc_q;
					res_q.cmd_count         <= 8'(acc_cnt_q);
					res_q.err_count         <= 8'(err_cnt_q);
					res_q.active_mode       <= mode_q;
					res_q.policy_enabled    <= flag_q;
					res_q.mode_change_count <= 16'(chg_cnt_q);
					res_q.age_sec           <= elapsed_q;
					res_q.draw_value        <= draw_q;
				end
			end
			default: begin
				hits_q <= hits_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign res      = res_q;

	`CAWG_ASSERT_NOW(a_draw_range, clk, arst_n, m_tvalid,
		res_q.draw_value < 7'(cawg_pkg::DRAW_MOD), "draw value out of range")
	`CAWG_ASSERT_NEXT(a_reject_counts, clk, arst_n, state_q == cawg_pkg::ST_APPLY && !gate_q,
		err_cnt_q == COUNT_WIDTH'($past(err_cnt_q) + 1'b1), "rejected request not counted")
	`CAWG_ASSERT_NOW(a_elapsed_ungated, clk, arst_n,
		state_q == cawg_pkg::ST_DONE && !is_gated, elapsed_q == '0,
		"elapsed time reported for an ungated request")

endmodule

>>> src/command_admission_window_gate_top.sv
// Command admission window gate: one request in, one result out. Ungated
// commands, gated commands under the open gate and a periodic gate with a zero
// period skip the shared remainder unit; the periodic gate waits on it for the
// window phase, the probabilistic gate for the window phase and then the draw.
// The unit resolves one bit per cycle (32 passes for the window phase, 16 more
// for the draw). s_tready is high only while no request is in work; one finished
// result can wait in the output register while the next request is taken.
//
// Top level: configuration registers, stream packing, sequencer and remainder
// unit. Depends on cawg_pkg, cawg_rem and cawg_ctrl.
module command_admission_window_gate_top #(
	parameter int COUNT_WIDTH  = 8,
	parameter int CHANGE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // now_sec[31:0], zero fill
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// cmd_count[7:0], err_count[15:8], active_mode[17:16], policy_enabled[18],
	// mode_change_count[34:19], age_sec[66:35], draw_value[73:67], zero fill
	output logic [79:0] m_tdata,
	output logic [0:0]  m_tuser,  // accepted[0]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cawg_pkg::cfg_t     cfg_q;
	cawg_pkg::div_req_t div_req;
	cawg_pkg::div_rsp_t div_rsp;
	cawg_pkg::res_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.profile   <= cawg_pkg::PROF_OPEN;
			cfg_q.staggered <= 1'b0;
			cfg_q.period    <= cawg_pkg::PERIOD_RESET;
			cfg_q.phase     <= '0;
			cfg_q.open_len  <= cawg_pkg::OPEN_LEN_RESET;
			cfg_q.seed_base <= cawg_pkg::SEED_RESET;
			cfg_q.ia_lo     <= cawg_pkg::INTERVAL_RESET[63:32];
			cfg_q.ia_hi     <= cawg_pkg::INTERVAL_RESET[31:0];
			cfg_q.ib_lo     <= cawg_pkg::INTERVAL_RESET[63:32];
			cfg_q.ib_hi     <= cawg_pkg::INTERVAL_RESET[31:0];
		end else if (cfg_we) begin
			case (cfg_index)
				cawg_pkg::REG_POLICY_PROFILE: cfg_q.profile   <= cfg_data[1:0];
				cawg_pkg::REG_STAGGERED:      cfg_q.staggered <= cfg_data[0];
				cawg_pkg::REG_PERIOD_SEC:     cfg_q.period    <= cfg_data[31:0];
				cawg_pkg::REG_PHASE_SEC:      cfg_q.phase     <= cfg_data[31:0];
				cawg_pkg::REG_OPEN_LEN_SEC:   cfg_q.open_len  <= cfg_data[31:0];
				cawg_pkg::REG_SEED_BASE:      cfg_q.seed_base <= cfg_data[31:0];
				cawg_pkg::REG_INTERVAL_A: begin
					cfg_q.ia_lo <= cfg_data[63:32];
					cfg_q.ia_hi <= cfg_data[31:0];
				end
				cawg_pkg::REG_INTERVAL_B: begin
					cfg_q.ib_lo <= cfg_data[63:32];
					cfg_q.ib_hi <= cfg_data[31:0];
				end
				default: begin
					cfg_q.profile <= cfg_q.profile;
				end
			endcase
		end
	end

	cawg_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	cawg_ctrl #(
		.COUNT_WIDTH  (COUNT_WIDTH),
		.CHANGE_WIDTH (CHANGE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (s_tuser),
		.now_sec  (s_tdata[31:0]),
		.cfg      (cfg_q),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tdata = {6'd0, res.draw_value, res.age_sec, res.mode_change_count,
		res.policy_enabled, res.active_mode, res.err_count, res.cmd_count};
	assign m_tuser = res.accepted;

endmodule
